@@ src/taylor_sine_cosine_tangent_unit_macros.svh @@
// assertion helpers shared by the unit
`ifndef TAYLOR_SINE_COSINE_TANGENT_UNIT_MACROS_SVH
`define TAYLOR_SINE_COSINE_TANGENT_UNIT_MACROS_SVH

// same-cycle implication
`define TSCU_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tscu assertion failed");

// next-cycle implication
`define TSCU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tscu assertion failed");

`endif

@@ src/tscu_pkg.sv @@
package tscu_pkg;

    localparam int SERIES_LIMIT_DEF  = 15;
    localparam int FRACTION_BITS_DEF = 24;

    localparam int WORK_BITS = 32;
    localparam int DEG_W     = 27;
    localparam int WIDE_W    = 32 + WORK_BITS;
    localparam int XM_W      = WIDE_W - 16;
    localparam int XW        = 36;
    localparam int TW        = 45;
    localparam int RW        = TW + 1;
    localparam int AW        = 48;
    localparam int OW        = 48;
    localparam int QW        = 50;
    localparam int MGW       = 52;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [DEG_W-1:0] DEG_FACTOR = 27'd74961353;
    localparam logic [XM_W-1:0]  ANGLE_LIM  = XM_W'(1) << (WORK_BITS + 3);
    localparam logic [MGW-1:0]   OUT_LIM    = MGW'(1) << (OW - 1);

    localparam logic [1:0] MODE_SIN = 2'd0;
    localparam logic [1:0] MODE_COS = 2'd1;
    localparam logic [1:0] MODE_TAN = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    typedef struct packed {
        logic signed [31:0] angle;
        logic [1:0]         mode;
        logic               in_degrees;
    } t_in;

    typedef struct packed {
        logic signed [OW-1:0] value;
        logic [1:0]           status;
    } t_out;

    typedef struct packed {
        logic [1:0]    mode;
        logic          sat;
        logic          x_neg;
        logic [XW-1:0] x_mag;
    } t_angle;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           mode;
        logic                 sat;
        logic                 x_neg;
        logic [XW-1:0]        x_mag;
        logic                 t_neg;
        logic [TW-1:0]        t_mag;
        logic signed [AW-1:0] sn;
        logic signed [AW-1:0] cs;
    } t_ser;

    typedef struct packed {
        logic [OW-1:0] value;
        logic          sat;
    } t_sat_res;

    function automatic t_sat_res sat_out(input logic [MGW-1:0] mag, input logic neg);
        t_sat_res res;
        res.sat   = 1'b0;
        res.value = '0;
        if (!neg && mag >= OUT_LIM) begin
            res.value = {1'b0, {(OW-1){1'b1}}};
            res.sat   = 1'b1;
        end else if (neg && mag > OUT_LIM) begin
            res.value = {1'b1, {(OW-1){1'b0}}};
            res.sat   = 1'b1;
        end else if (neg) begin
            res.value = -mag[OW-1:0];
        end else begin
            res.value = mag[OW-1:0];
        end
        return res;
    endfunction

endpackage

@@ src/tscu_front.sv @@
module tscu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  tscu_pkg::t_in   i_data,
    output logic            o_push,
    input  logic            i_full,
    output tscu_pkg::t_angle o_angle
);
    import tscu_pkg::*;

    logic              r_f1_valid;
    logic              r_f1_neg;
    logic [31:0]       r_f1_mag;
    logic [1:0]        r_f1_mode;
    logic              r_f1_deg;
    logic              r_f2_valid;
    logic              r_f2_neg;
    logic [1:0]        r_f2_mode;
    logic [WIDE_W-1:0] r_f2_wide;

    logic              f1_ready;
    logic              f2_ready;
    logic [31:0]       n_f1_mag;
    logic [WIDE_W-1:0] n_f2_wide;
    logic [XM_W-1:0]   xm;

    assign f2_ready = !r_f2_valid || !i_full;
    assign f1_ready = !r_f1_valid || f2_ready;
    assign o_stall  = !f1_ready;
    assign o_push   = r_f2_valid && !i_full;

    always_comb begin
        n_f1_mag = i_data.angle[31] ? (~i_data.angle + 32'd1) : i_data.angle;
        n_f2_wide = r_f1_deg ? WIDE_W'(r_f1_mag) * WIDE_W'(DEG_FACTOR)
                             : WIDE_W'(r_f1_mag) << WORK_BITS;
    end

    // degree product or shifted radian value back to Q.32, then clamp
    always_comb begin
        xm = XM_W'((r_f2_wide + WIDE_W'(16'h8000)) >> 16);
        o_angle.mode  = r_f2_mode;
        o_angle.x_neg = r_f2_neg;
        if (xm > ANGLE_LIM) begin
            o_angle.x_mag = XW'(ANGLE_LIM);
            o_angle.sat   = 1'b1;
        end else begin
            o_angle.x_mag = XW'(xm);
            o_angle.sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (f1_ready) begin
            r_f1_valid <= i_valid;
            r_f1_neg   <= i_data.angle[31];
            r_f1_mag   <= n_f1_mag;
            r_f1_mode  <= i_data.mode;
            r_f1_deg   <= i_data.in_degrees;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_valid <= 1'b0;
        end else if (f2_ready) begin
            r_f2_valid <= r_f1_valid;
            r_f2_neg   <= r_f1_neg;
            r_f2_mode  <= r_f1_mode;
            r_f2_wide  <= n_f2_wide;
        end
    end

endmodule

@@ src/tscu_fifo.sv @@
`include "taylor_sine_cosine_tangent_unit_macros.svh"

module tscu_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tscu_pkg::t_angle i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output tscu_pkg::t_angle o_data
);
    import tscu_pkg::*;

    t_angle             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = r_count == (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `TSCU_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, o_full && !i_pop, !i_push)
    `TSCU_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, r_count == '0, !i_pop)
    `TSCU_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

@@ src/tscu_term.sv @@
module tscu_term #(
    parameter int K = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  tscu_pkg::t_ser i_d,
    output tscu_pkg::t_ser o_d
);
    import tscu_pkg::*;

    localparam int TLO = 23;
    localparam int THI = TW - TLO;
    localparam int SW  = TW + XW;
    localparam int DW  = TW + RW;
    localparam int PW  = TW + 6;
    localparam logic [RW-1:0] RECIP  = RW'((64'd1 << TW) / K);
    localparam logic [TW-1:0] HALF_K = TW'(K / 2);
    localparam logic [PW-1:0] K_W    = PW'(K);
    localparam logic [1:0]    PHASE  = 2'(K % 4);

    t_ser              r_a, r_b, r_c, r_d, r_e;
    logic [TLO+XW-1:0] r_a_p0;
    logic [THI+XW-1:0] r_a_p1;
    logic [TW-1:0]     r_b_n, r_c_n, r_d_n;
    logic [TLO+RW-1:0] r_c_p0;
    logic [THI+RW-1:0] r_c_p1;
    logic [TW-1:0]     r_d_q0;

    t_ser              n_a, n_e;
    logic [SW-1:0]     n_b_sum;
    logic [TW-1:0]     n_b_n;
    logic [DW-1:0]     n_d_sum;
    logic [PW-1:0]     e_rem;
    logic [TW-1:0]     e_q;
    logic signed [AW-1:0] e_t;

    always_comb begin
        n_a       = i_d;
        n_a.t_neg = i_d.t_neg ^ i_d.x_neg;
    end

    // product round to Q.32, then bias for the divide by k
    always_comb begin
        n_b_sum = SW'({r_a_p1, {TLO{1'b0}}}) + SW'(r_a_p0) + (SW'(1) << (WORK_BITS - 1));
        n_b_n   = n_b_sum[TW+WORK_BITS-1:WORK_BITS] + HALF_K;
    end

    always_comb begin
        n_d_sum = DW'({r_c_p1, {TLO{1'b0}}}) + DW'(r_c_p0);
    end

    // reciprocal quotient is low by at most one
    always_comb begin
        e_rem = PW'(r_d_n) - PW'(r_d_q0) * K_W;
        e_q   = (e_rem >= K_W) ? r_d_q0 + 1'b1 : r_d_q0;
        e_t   = r_d.t_neg ? -AW'(e_q) : AW'(e_q);
        n_e       = r_d;
        n_e.t_mag = e_q;
        case (PHASE)
            2'd0:    n_e.cs = r_d.cs + e_t;
            2'd1:    n_e.sn = r_d.sn + e_t;
            2'd2:    n_e.cs = r_d.cs - e_t;
            default: n_e.sn = r_d.sn - e_t;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            r_d.valid <= 1'b0;
            r_e.valid <= 1'b0;
        end else if (i_en) begin
            r_a    <= n_a;
            r_a_p0 <= (TLO+XW)'(i_d.t_mag[TLO-1:0]) * (TLO+XW)'(i_d.x_mag);
            r_a_p1 <= (THI+XW)'(i_d.t_mag[TW-1:TLO]) * (THI+XW)'(i_d.x_mag);
            r_b    <= r_a;
            r_b_n  <= n_b_n;
            r_c    <= r_b;
            r_c_n  <= r_b_n;
            r_c_p0 <= (TLO+RW)'(r_b_n[TLO-1:0]) * (TLO+RW)'(RECIP);
            r_c_p1 <= (THI+RW)'(r_b_n[TW-1:TLO]) * (THI+RW)'(RECIP);
            r_d    <= r_c;
            r_d_n  <= r_c_n;
            r_d_q0 <= n_d_sum[2*TW-1:TW];
            r_e    <= n_e;
        end
    end

    assign o_d = r_e;

endmodule

@@ src/tscu_back.sv @@
`include "taylor_sine_cosine_tangent_unit_macros.svh"

module tscu_back #(
    parameter int SERIES_LIMIT  = tscu_pkg::SERIES_LIMIT_DEF,
    parameter int FRACTION_BITS = tscu_pkg::FRACTION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tscu_pkg::t_angle i_data,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output tscu_pkg::t_out   o_data
);
    import tscu_pkg::*;

    localparam int NW = AW + FRACTION_BITS + 1;
    localparam int SH = WORK_BITS - FRACTION_BITS;
    localparam logic [MGW-1:0] HALF_OUT = (MGW'(1) << SH) >> 1;

    typedef struct packed {
        logic          valid;
        logic [1:0]    mode;
        logic          sat;
        logic          czero;
        logic          tneg;
        logic [AW-1:0] d;
        logic [AW-1:0] rem;
        logic [NW-1:0] num;
        logic [QW-1:0] q;
        logic          ovf;
        logic [OW-1:0] dval;
    } t_div;

    logic   en;
    t_ser   r_s0;
    t_ser   n_s0;
    t_ser   w_chain [SERIES_LIMIT];
    t_div   r_dv [NW+1];
    t_div   n_dv0;
    logic   r_out_valid;
    t_out   r_out;
    t_out   n_out;

    t_ser          s_last;
    logic signed [AW-1:0] o1_v;
    logic [AW-1:0] o1_vm;
    logic [AW-1:0] o1_sm;
    logic [AW-1:0] o1_cm;
    t_sat_res      o1_res;
    logic [MGW-1:0] f_mag;
    t_sat_res      f_res;
    t_div          f_dv;

    assign en      = !r_out_valid || !i_stall;
    assign o_pop   = en && i_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_s0.valid = i_valid;
        n_s0.mode  = i_data.mode;
        n_s0.sat   = i_data.sat;
        n_s0.x_neg = i_data.x_neg;
        n_s0.x_mag = i_data.x_mag;
        n_s0.t_neg = 1'b0;
        n_s0.t_mag = TW'(1) << WORK_BITS;
        n_s0.sn    = '0;
        n_s0.cs    = AW'(1) << WORK_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (en) begin
            r_s0 <= n_s0;
        end
    end

    assign w_chain[0] = r_s0;

    for (genvar gk = 1; gk < SERIES_LIMIT; gk++) begin : g_term
        tscu_term #(.K(gk)) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (w_chain[gk-1]),
            .o_d     (w_chain[gk])
        );
    end

    assign s_last = w_chain[SERIES_LIMIT-1];

    // sine or cosine output, divider setup for tangent
    always_comb begin
        o1_v   = (s_last.mode == MODE_SIN) ? s_last.sn : s_last.cs;
        o1_vm  = o1_v[AW-1] ? AW'(-o1_v) : AW'(o1_v);
        o1_sm  = s_last.sn[AW-1] ? AW'(-s_last.sn) : AW'(s_last.sn);
        o1_cm  = s_last.cs[AW-1] ? AW'(-s_last.cs) : AW'(s_last.cs);
        o1_res = sat_out((MGW'(o1_vm) + HALF_OUT) >> SH, o1_v[AW-1]);
        n_dv0.valid = s_last.valid;
        n_dv0.mode  = s_last.mode;
        n_dv0.sat   = s_last.sat;
        n_dv0.czero = s_last.cs == '0;
        n_dv0.tneg  = s_last.sn[AW-1] ^ s_last.cs[AW-1];
        n_dv0.d     = o1_cm;
        n_dv0.rem   = '0;
        n_dv0.num   = NW'(o1_sm) << (FRACTION_BITS + 1);
        n_dv0.q     = '0;
        n_dv0.ovf   = 1'b0;
        n_dv0.dval  = o1_res.value;
        if (s_last.mode != MODE_TAN) begin
            n_dv0.sat = s_last.sat | o1_res.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].valid <= 1'b0;
        end else if (en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar gi = 0; gi < NW; gi++) begin : g_div
        t_div        n_dv;
        logic [AW:0] rs;
        logic        ge;

        always_comb begin
            rs        = {r_dv[gi].rem, r_dv[gi].num[NW-1]};
            ge        = rs >= {1'b0, r_dv[gi].d};
            n_dv      = r_dv[gi];
            n_dv.rem  = ge ? AW'(rs - {1'b0, r_dv[gi].d}) : rs[AW-1:0];
            n_dv.num  = r_dv[gi].num << 1;
            n_dv.q    = {r_dv[gi].q[QW-2:0], ge};
            n_dv.ovf  = r_dv[gi].ovf | r_dv[gi].q[QW-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[gi+1].valid <= 1'b0;
            end else if (en) begin
                r_dv[gi+1] <= n_dv;
            end
        end
    end

    always_comb begin
        f_dv  = r_dv[NW];
        f_mag = f_dv.ovf ? {MGW{1'b1}} : (MGW'(f_dv.q) + 1'b1) >> 1;
        f_res = sat_out(f_mag, f_dv.tneg);
        n_out.value  = '0;
        n_out.status = STAT_OK;
        if (f_dv.mode == MODE_TAN) begin
            if (f_dv.czero) begin
                n_out.status = STAT_ZERO;
            end else begin
                n_out.value  = f_res.value;
                n_out.status = (f_dv.sat || f_res.sat) ? STAT_SAT : STAT_OK;
            end
        end else if (f_dv.mode == MODE_SIN || f_dv.mode == MODE_COS) begin
            n_out.value  = f_dv.dval;
            n_out.status = f_dv.sat ? STAT_SAT : STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= f_dv.valid;
            r_out       <= n_out;
        end
    end

    `TSCU_ASSERT_IMPL(a_zero_cos_value, i_clk, i_rst_n, r_out_valid && r_out.status == STAT_ZERO, r_out.value == '0)

endmodule

@@ src/taylor_sine_cosine_tangent_unit.sv @@
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_in_data   (angle, mode, in_degrees)
// output    out        o_out_valid / i_out_stall o_out_data  (value, status)
//
// one transfer per cycle in each direction when neither side stalls
// pipeline: 2 front stages, queue, 1 + 5*(SERIES_LIMIT-1) series stages,
//   1 + (FRACTION_BITS+49) divider stages, 1 output register
// the series multiplies and the one-bit-per-stage tangent divider set that depth
// synchronous active-low reset clears all valid flags and the queue
// an output stall freezes the back pipeline; the front keeps filling the 4-entry queue
module taylor_sine_cosine_tangent_unit #(
    parameter int SERIES_LIMIT  = tscu_pkg::SERIES_LIMIT_DEF,
    parameter int FRACTION_BITS = tscu_pkg::FRACTION_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tscu_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tscu_pkg::t_out o_out_data
);
    import tscu_pkg::*;

    logic   push;
    logic   full;
    logic   pop;
    logic   q_valid;
    t_angle front_angle;
    t_angle q_angle;

    tscu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .o_push  (push),
        .i_full  (full),
        .o_angle (front_angle)
    );

    tscu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_angle),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_angle)
    );

    tscu_back #(
        .SERIES_LIMIT  (SERIES_LIMIT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (q_angle),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

@@ tb/tb_trig_checker.sv @@
module tb_trig_checker
    import tscu_pkg::*;
#(
    parameter int SERIES_LIMIT  = SERIES_LIMIT_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_saturated
);

    localparam longint signed ANGLE_MAX = 64'sd8 <<< WORK_BITS;
    localparam longint signed VAL_MAX   = 64'sh7FFFFFFFFFFF;
    localparam longint signed VAL_MIN   = -64'sh800000000000;
    localparam longint unsigned MAG_LIM = 64'd1 << 47;

    t_out expected_results[$];

    function automatic longint unsigned magnitude(input longint signed v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint signed signed_of(input longint unsigned m, input logic neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint signed mul_round(input longint signed a, input longint signed b);
        logic [127:0] p;
        p = 128'(magnitude(a)) * 128'(magnitude(b));
        p = (p + 128'h8000_0000) >> 32;
        return signed_of(p[63:0], (a < 0) != (b < 0));
    endfunction

    function automatic longint signed div_round(input longint signed a, input int k);
        longint unsigned ua;
        ua = magnitude(a);
        return signed_of((ua + longint'(k / 2)) / longint'(k), a < 0);
    endfunction

    function automatic longint signed clip48(input longint signed v, inout logic sat);
        if (v > VAL_MAX) begin
            sat = 1'b1;
            return VAL_MAX;
        end
        if (v < VAL_MIN) begin
            sat = 1'b1;
            return VAL_MIN;
        end
        return v;
    endfunction

    function automatic longint signed scale_out(input longint signed v, inout logic sat);
        longint unsigned m;
        int sh;
        m = magnitude(v);
        sh = WORK_BITS - FRACTION_BITS;
        if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
        if (m > MAG_LIM) begin
            sat = 1'b1;
            return v < 0 ? VAL_MIN : VAL_MAX;
        end
        return clip48(signed_of(m, v < 0), sat);
    endfunction

    function automatic longint signed divide_tan(input longint signed s, input longint signed c,
                                                 inout logic sat);
        longint unsigned n, d, q, r;
        logic neg;
        n = magnitude(s);
        d = magnitude(c);
        neg = (s < 0) != (c < 0);
        q = n / d;
        r = n % d;
        if (q > MAG_LIM) begin
            sat = 1'b1;
            return neg ? VAL_MIN : VAL_MAX;
        end
        for (int i = 0; i < FRACTION_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
            if (q > MAG_LIM) begin
                sat = 1'b1;
                return neg ? VAL_MIN : VAL_MAX;
            end
        end
        r = r << 1;
        if (r >= d) q = q + 1;
        if (q > MAG_LIM) begin
            sat = 1'b1;
            return neg ? VAL_MIN : VAL_MAX;
        end
        return clip48(signed_of(q, neg), sat);
    endfunction

    function automatic t_out predict_trig(input t_in d);
        t_out res;
        longint signed a, x, term, sn, cs, val;
        longint unsigned m;
        logic sat;
        sat = 1'b0;
        a = longint'(d.angle);
        if (d.in_degrees) begin
            m = magnitude(a) * longint'(DEG_FACTOR);
            x = signed_of((m + 64'h8000) >> 16, a < 0);
        end else begin
            x = a * 65536;
        end
        if (x > ANGLE_MAX) begin
            x = ANGLE_MAX;
            sat = 1'b1;
        end
        if (x < -ANGLE_MAX) begin
            x = -ANGLE_MAX;
            sat = 1'b1;
        end
        sn = 0;
        cs = 64'sd1 <<< WORK_BITS;
        term = cs;
        for (int k = 1; k < SERIES_LIMIT; k++) begin
            term = div_round(mul_round(term, x), k);
            case (k % 4)
                0: cs = cs + term;
                1: sn = sn + term;
                2: cs = cs - term;
                default: sn = sn - term;
            endcase
        end
        res.status = STAT_OK;
        val = 0;
        case (d.mode)
            MODE_SIN: begin
                val = scale_out(sn, sat);
                res.status = sat ? STAT_SAT : STAT_OK;
            end
            MODE_COS: begin
                val = scale_out(cs, sat);
                res.status = sat ? STAT_SAT : STAT_OK;
            end
            MODE_TAN: begin
                if (cs == 0) begin
                    res.status = STAT_ZERO;
                end else begin
                    val = divide_tan(sn, cs, sat);
                    res.status = sat ? STAT_SAT : STAT_OK;
                end
            end
            default: val = 0;
        endcase
        res.value = val[OW-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_checked = 0;
        o_saturated = 0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out exp_res;
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            exp_res = predict_trig(i_in_data);
            if (exp_res.status != STAT_OK) o_saturated++;
            expected_results.push_back(exp_res);
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                exp_res = expected_results.pop_front();
                o_checked++;
                if (i_out_data.value !== exp_res.value)
                    report_mismatch($sformatf("value got %h want %h",
                                              i_out_data.value, exp_res.value));
                if (i_out_data.status !== exp_res.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              i_out_data.status, exp_res.status));
            end
        end
    end

endmodule

@@ tb/tb.sv @@
module tb;
    import tscu_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    int errors, pending, checked, saturated;
    int idle_pct, stall_pct;
    logic hold_out;
    int sent;

    taylor_sine_cosine_tangent_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    tb_trig_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .o_errors(errors), .o_pending(pending), .o_checked(checked),
        .o_saturated(saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_out_stall <= hold_out || ($urandom_range(99) < stall_pct);
    end

    task automatic send_angle(input t_in d);
        @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    function automatic t_in random_angle();
        t_in d;
        int pick;
        pick = $urandom_range(9);
        d.mode = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
        d.in_degrees = 1'b0;
        if (pick < 6) begin
            d.angle = $signed($urandom_range(1200000)) - 600000;
        end else if (pick < 8) begin
            d.in_degrees = 1'b1;
            d.angle = $signed($urandom_range(62000000)) - 31000000;
        end else begin
            d.angle = $urandom;
            d.in_degrees = 1'($urandom_range(1));
        end
        return d;
    endfunction

    task automatic send_directed(input logic [31:0] a, input logic deg);
        t_in d;
        for (int m = 0; m < 4; m++) begin
            d.angle = a;
            d.mode = 2'(m);
            d.in_degrees = deg;
            if (m < 3 || a == 32'd0) send_angle(d);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        hold_out = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        sent = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_directed(32'h0000_0000, 1'b0);
        send_directed(32'h7FFF_FFFF, 1'b0);
        send_directed(32'h8000_0000, 1'b1);
        send_directed(32'h0008_0000, 1'b0);
        send_directed(32'hFFF7_FFFF, 1'b0);
        send_directed(32'h0001_9220, 1'b0);
        send_directed(32'h005A_0000, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            if (phase == 0) begin
                fork
                    begin
                        @(negedge i_clk);
                        hold_out <= 1'b1;
                        repeat (300) @(negedge i_clk);
                        hold_out <= 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 333; n++) send_angle(random_angle());
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);

        $display("sent %0d angles over sine, cosine, tangent and both units", sent);
        $display("checked %0d results, %0d with a nonzero status, across four stall mixes",
                 checked, saturated);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
